FILE: hdl/plil_pkg.sv
// Package for the positional insert/remove list core.
// Holds the payload structs, operation and status codes, sizes and the
// controller-to-datapath command struct. No dependencies.
package plil_pkg;

  localparam int DEPTH          = 128;
  localparam int ADDR_W         = $clog2(DEPTH);
  localparam int CNT_W          = 8;
  localparam int DATA_W         = 32;
  localparam logic [CNT_W-1:0] CAPACITY_RESET = 8'd100;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    op_t                      op;
    logic [CNT_W-1:0]         pos;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [CNT_W-1:0]         count;
    status_t                  status;
  } rsp_t;

  // command bundle from controller to datapath
  typedef struct packed {
    logic              load_value;
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic              wsel_value;
    logic              clr_data;
    logic              cap_data;
    logic              res_load;
    logic [CNT_W-1:0]  res_count;
    status_t           res_status;
  } dp_cmd_t;

endpackage

FILE: hdl/plil_dpath.sv
// Datapath of the list core: entry memory with registered read, held insert
// word, captured read word and the result register. Uses plil_pkg.
module plil_dpath import plil_pkg::*; (
  input  logic                     clk,
  input  dp_cmd_t                  cmd,
  input  logic signed [DATA_W-1:0] value,
  output rsp_t                     rsp
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata;
  logic [DATA_W-1:0] value_q;
  logic [DATA_W-1:0] data_q;

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.waddr] <= cmd.wsel_value ? value_q : rdata;
    end
    if (cmd.re) begin
      rdata <= mem[cmd.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_value) begin
      value_q <= value;
    end
    if (cmd.clr_data) begin
      data_q <= '0;
    end else if (cmd.cap_data) begin
      data_q <= rdata;
    end
    if (cmd.res_load) begin
      rsp.data   <= data_q;
      rsp.count  <= cmd.res_count;
      rsp.status <= cmd.res_status;
    end
  end

endmodule

FILE: hdl/plil_ctrl.sv
// Controller of the list core: operation sequencer, length and capacity
// registers, handshakes. Drives plil_dpath through dp_cmd_t. Uses plil_pkg.
module plil_ctrl import plil_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  op_t              req_op,
  input  logic [CNT_W-1:0] req_pos,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data,
  output dp_cmd_t          cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_POS,
    S_SH_RD,
    S_SH_WR,
    S_INS_WR,
    S_DONE
  } state_t;

  state_t            state;
  op_t               op_q;
  logic [CNT_W-1:0]  pos_q;
  logic [ADDR_W-1:0] idx;
  logic [CNT_W-1:0]  used_count;
  logic [CNT_W-1:0]  capacity;
  status_t           status_q;

  logic [CNT_W-1:0]  limit;
  logic              accept;
  status_t           acc_status;
  logic              publish;
  logic [CNT_W-1:0]  idx_up1;
  logic [CNT_W-1:0]  idx_up2;
  logic [ADDR_W-1:0] idx_dn1;

  assign limit     = (int'(capacity) > DEPTH) ? CNT_W'(DEPTH) : capacity;
  assign accept    = req_valid && (state == S_IDLE);
  assign req_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign publish   = (state == S_DONE) && (!rsp_valid || !rsp_stall);
  assign idx_up1   = CNT_W'(idx) + CNT_W'(1);
  assign idx_up2   = CNT_W'(idx) + CNT_W'(2);
  assign idx_dn1   = idx - ADDR_W'(1);

  // position check wins over the full check
  always_comb begin
    acc_status = ST_OK;
    unique case (req_op)
      OP_INSERT: begin
        if (req_pos > used_count)       acc_status = ST_RANGE;
        else if (used_count >= limit)   acc_status = ST_FULL;
      end
      OP_REMOVE, OP_READ: begin
        if (req_pos >= used_count)      acc_status = ST_RANGE;
      end
      default: acc_status = ST_OK;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.load_value = accept;
    cmd.clr_data   = accept;
    cmd.res_load   = publish;
    cmd.res_count  = used_count;
    cmd.res_status = status_q;
    unique case (state)
      S_IDLE: begin
        cmd.re    = accept;
        cmd.raddr = req_pos[ADDR_W-1:0];
      end
      S_RD_POS: cmd.cap_data = 1'b1;
      S_SH_RD: begin
        cmd.re    = 1'b1;
        cmd.raddr = (op_q == OP_INSERT) ? idx_dn1 : idx_up1[ADDR_W-1:0];
      end
      S_SH_WR: begin
        cmd.we    = 1'b1;
        cmd.waddr = idx;
      end
      S_INS_WR: begin
        cmd.we         = 1'b1;
        cmd.waddr      = pos_q[ADDR_W-1:0];
        cmd.wsel_value = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used_count <= '0;
      capacity   <= CAPACITY_RESET;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      if (publish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q     <= req_op;
            pos_q    <= req_pos;
            status_q <= acc_status;
            if (acc_status != ST_OK) begin
              state <= S_DONE;
            end else begin
              unique case (req_op)
                OP_INSERT: begin
                  idx   <= used_count[ADDR_W-1:0];
                  state <= (req_pos == used_count) ? S_INS_WR : S_SH_RD;
                end
                OP_REMOVE, OP_READ: state <= S_RD_POS;
                default: begin
                  used_count <= '0;
                  state      <= S_DONE;
                end
              endcase
            end
          end
        end
        S_RD_POS: begin
          if (op_q == OP_READ) begin
            state <= S_DONE;
          end else begin
            idx <= pos_q[ADDR_W-1:0];
            if (pos_q + CNT_W'(1) < used_count) begin
              state <= S_SH_RD;
            end else begin
              used_count <= used_count - CNT_W'(1);
              state      <= S_DONE;
            end
          end
        end
        S_SH_RD: state <= S_SH_WR;
        S_SH_WR: begin
          if (op_q == OP_INSERT) begin
            idx   <= idx_dn1;
            state <= (idx_dn1 == pos_q[ADDR_W-1:0]) ? S_INS_WR : S_SH_RD;
          end else begin
            idx <= idx_up1[ADDR_W-1:0];
            if (idx_up2 < used_count) begin
              state <= S_SH_RD;
            end else begin
              used_count <= used_count - CNT_W'(1);
              state      <= S_DONE;
            end
          end
        end
        S_INS_WR: begin
          used_count <= used_count + CNT_W'(1);
          state      <= S_DONE;
        end
        S_DONE: begin
          if (publish) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/positional_insert_remove_list_core.sv
// Top level of the positional insert/remove list core.
// Instantiates plil_ctrl and plil_dpath; uses plil_pkg.
//
// Usage:
//   req channel (req_valid/req_stall, payload req): one operation per transfer,
//   insert, remove, read or clear at a position. rsp channel (rsp_valid/
//   rsp_stall, payload rsp): exactly one result per operation, in order, with
//   the word removed or read, the length after the operation and a status.
//   cfg channel (cfg_valid/cfg_ready, cfg_data): writes the capacity limit;
//   always ready, write only while no operation is in flight.
// Sequence from request transfer to result valid: a rejected op or a clear
//   goes straight to done; a read captures the word; an insert shifts the
//   entries from the position up, then writes the word; a remove captures the
//   word, then shifts the entries above it down, one word per registered read
//   and write. A new request is taken once the previous result is in the
//   output register, even while that result is still stalled.
// Reset: length zero, capacity 100, no result pending. Entry memory is not
//   cleared; words at or above the length never reach a result.
// Stall: a stalled result holds; the next operation finishes its work and
//   waits until the output register frees up.
module positional_insert_remove_list_core import plil_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_t             rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  dp_cmd_t cmd;

  plil_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_op    (req.op),
    .req_pos   (req.pos),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd)
  );

  plil_dpath u_dpath (
    .clk   (clk),
    .cmd   (cmd),
    .value (req.value),
    .rsp   (rsp)
  );

endmodule

FILE: hdl/plil_check.sv
// Port-level checker for the list core, bound to the top level.
// Uses plil_pkg and positional_insert_remove_list_core.
module plil_check import plil_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // held result must not move
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_OK) |-> rsp.data == '0)
    else $error("rejected op returned data");

  a_rsp_legal: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == ST_OK || rsp.status == ST_RANGE ||
                   rsp.status == ST_FULL) && (int'(rsp.count) <= DEPTH))
    else $error("bad status or count");

  // one operation at a time
  a_take_stall: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("no stall after a request transfer");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid && !req_stall)
    else $error("not idle after reset");

endmodule

bind positional_insert_remove_list_core plil_check u_check (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

FILE: verif/plil_list_checker.sv
`timescale 1ns / 100ps
// Result checker for positional_insert_remove_list_core: follows the request,
// result and capacity channels, predicts every result and compares it.
// Depends on plil_pkg only.
module plil_list_checker import plil_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic             req_stall,
  input  req_t             req,
  input  logic             rsp_valid,
  input  logic             rsp_stall,
  input  rsp_t             rsp,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data,
  output int               errors,
  output int               outstanding,
  output logic [CNT_W-1:0] len_hint,
  output int               results_seen,
  output int               full_seen,
  output int               range_seen
);

  localparam int SHOW_MAX = 20;

  logic signed [DATA_W-1:0] list_mem [DEPTH];
  logic [CNT_W-1:0]         list_len;
  logic [CNT_W-1:0]         cap_q;
  rsp_t                     expected_rsp [$];
  int                       err_cnt;
  int                       n_res;
  int                       n_full;
  int                       n_range;

  // applies one operation to the shadow list and returns its result
  function automatic rsp_t predict_list_op(req_t r);
    rsp_t o;
    int   lim;
    int   i;
    o = '0;
    o.status = ST_OK;
    lim = (cap_q > DEPTH) ? DEPTH : cap_q;
    case (r.op)
      OP_INSERT: begin
        // a bad position wins over a full list
        if (r.pos > list_len) begin
          o.status = ST_RANGE;
        end else if (list_len >= lim) begin
          o.status = ST_FULL;
        end else begin
          for (i = list_len; i > r.pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[r.pos] = r.value;
          list_len = list_len + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (r.pos >= list_len) begin
          o.status = ST_RANGE;
        end else begin
          o.data = list_mem[r.pos];
          for (i = r.pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_mem[list_len-1] = '0;
          list_len = list_len - 1'b1;
        end
      end
      OP_READ: begin
        if (r.pos >= list_len) o.status = ST_RANGE;
        else o.data = list_mem[r.pos];
      end
      OP_CLEAR: begin
        foreach (list_mem[k]) list_mem[k] = '0;
        list_len = '0;
      end
    endcase
    o.count = list_len;
    return o;
  endfunction

  task automatic flag_field(input string fname, input logic [31:0] want,
                            input logic [31:0] got);
    err_cnt++;
    if (err_cnt <= SHOW_MAX)
      $display("%0t: %s mismatch, expected 0x%08h got 0x%08h", $time, fname, want, got);
  endtask

  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      foreach (list_mem[k]) list_mem[k] = '0;
      list_len = '0;
      cap_q    = CAPACITY_RESET;
      expected_rsp.delete();
      err_cnt = 0;
      n_res   = 0;
      n_full  = 0;
      n_range = 0;
    end else begin
      if (cfg_valid && cfg_ready) cap_q = cfg_data;
      if (rsp_valid && !rsp_stall) begin
        n_res++;
        if (expected_rsp.size() == 0) begin
          err_cnt++;
          if (err_cnt <= SHOW_MAX)
            $display("%0t: result with nothing pending, expected none got 0x%08h/%0d/%0d",
                     $time, rsp.data, rsp.count, rsp.status);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.data !== want.data) flag_field("data", want.data, rsp.data);
          if (rsp.count !== want.count)
            flag_field("count", 32'(want.count), 32'(rsp.count));
          if (rsp.status !== want.status)
            flag_field("status", 32'(want.status), 32'(rsp.status));
          if (want.status == ST_FULL) n_full++;
          if (want.status == ST_RANGE) n_range++;
        end
      end
      if (req_valid && !req_stall) expected_rsp.push_back(predict_list_op(req));
    end
    errors       <= err_cnt;
    outstanding  <= expected_rsp.size();
    len_hint     <= list_len;
    results_seen <= n_res;
    full_seen    <= n_full;
    range_seen   <= n_range;
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// Testbench top for positional_insert_remove_list_core: drives operations,
// capacity writes and result back-pressure, and gives the verdict.
// Depends on plil_pkg, plil_list_checker and positional_insert_remove_list_core.
module tb;
  import plil_pkg::*;

  localparam int IDLE_LIMIT = 4000;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_stall;
  req_t             req       = '0;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  rsp_t             rsp;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data  = '0;

  int               errors;
  int               outstanding;
  logic [CNT_W-1:0] len_hint;
  int               results_seen;
  int               full_seen;
  int               range_seen;

  bit               calm = 1'b0;
  int               stall_hold = 0;
  int               idle_cyc = 0;
  int               ops_sent = 0;
  int               cap_writes = 0;

  always #4 clk = ~clk;

  positional_insert_remove_list_core DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  plil_list_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req          (req),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .rsp          (rsp),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .outstanding  (outstanding),
    .len_hint     (len_hint),
    .results_seen (results_seen),
    .full_seen    (full_seen),
    .range_seen   (range_seen)
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic req_t op_item(op_t o, logic [CNT_W-1:0] p, logic [DATA_W-1:0] v);
    req_t it;
    it.op    = o;
    it.pos   = p;
    it.value = v;
    return it;
  endfunction

  // filling favors inserts; otherwise removes and reads dominate
  function automatic req_t rand_item(bit filling, int len);
    req_t it;
    int   r;
    int   p;
    r = $urandom_range(0, 99);
    if (filling) it.op = (r < 84) ? OP_INSERT : (r < 90) ? OP_REMOVE : OP_READ;
    else it.op = (r < 15) ? OP_INSERT : (r < 68) ? OP_REMOVE : (r < 97) ? OP_READ : OP_CLEAR;
    r = $urandom_range(0, 99);
    if (r < 86) begin
      if (it.op == OP_INSERT) p = $urandom_range(0, len);
      else p = (len > 0) ? $urandom_range(0, len - 1) : 0;
    end else if (r < 89) begin
      p = 0;
    end else if (r < 92) begin
      p = len;
    end else begin
      p = $urandom_range(0, 255);
    end
    it.pos = p[CNT_W-1:0];
    r = $urandom_range(0, 99);
    if (r < 5) it.value = 32'h7fff_ffff;
    else if (r < 10) it.value = 32'h8000_0000;
    else if (r < 13) it.value = '0;
    else if (r < 16) it.value = '1;
    else it.value = $urandom;
    return it;
  endfunction

  // holds the item until its transfer edge
  task automatic push_req(input req_t item);
    int gap;
    gap = calm ? 0 : gap_len();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    ops_sent++;
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cap(input logic [CNT_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cap_writes++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall  <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      rsp_stall  <= !calm && ($urandom_range(0, 2) == 0);
      stall_hold <= gap_len();
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  initial begin : stimulus
    logic [CNT_W-1:0] caps [8];
    int               n;
    caps = '{8'd128, 8'd5, 8'd1, 8'd24, 8'd100, 8'd2, 8'd0, 8'd127};
    caps[6] = CNT_W'($urandom_range(1, 128));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset capacity, empty list, then a few words at both ends and in between
    push_req(op_item(OP_READ,   8'd0,   $urandom));
    push_req(op_item(OP_REMOVE, 8'd0,   $urandom));
    push_req(op_item(OP_INSERT, 8'd1,   32'h1234_5678));
    push_req(op_item(OP_INSERT, 8'd0,   32'h7fff_ffff));
    push_req(op_item(OP_INSERT, 8'd0,   32'h8000_0000));
    push_req(op_item(OP_INSERT, 8'd2,   32'hffff_ffff));
    push_req(op_item(OP_INSERT, 8'd1,   32'h0000_0000));
    push_req(op_item(OP_INSERT, 8'd5,   32'h0000_0123));
    push_req(op_item(OP_READ,   8'd0,   $urandom));
    push_req(op_item(OP_READ,   8'd3,   $urandom));
    push_req(op_item(OP_READ,   8'd4,   $urandom));
    push_req(op_item(OP_READ,   8'd255, $urandom));
    push_req(op_item(OP_INSERT, 8'd255, $urandom));
    push_req(op_item(OP_REMOVE, 8'd1,   $urandom));
    push_req(op_item(OP_REMOVE, 8'd2,   $urandom));
    push_req(op_item(OP_REMOVE, 8'd2,   $urandom));
    push_req(op_item(OP_READ,   8'd128, $urandom));
    wait_idle();
    // list at capacity: full, and bad position takes precedence
    write_cap(8'd2);
    push_req(op_item(OP_INSERT, 8'd0,   32'h5a5a_5a5a));
    push_req(op_item(OP_INSERT, 8'd3,   32'ha5a5_a5a5));
    wait_idle();
    // capacity lowered below current length
    write_cap(8'd1);
    push_req(op_item(OP_INSERT, 8'd1,   $urandom));
    push_req(op_item(OP_REMOVE, 8'd0,   $urandom));
    push_req(op_item(OP_INSERT, 8'd0,   $urandom));
    wait_idle();
    // zero capacity rejects every insert
    write_cap(8'd0);
    push_req(op_item(OP_CLEAR,  8'd0,   $urandom));
    push_req(op_item(OP_INSERT, 8'd0,   $urandom));
    push_req(op_item(OP_READ,   8'd0,   $urandom));

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      write_cap(caps[ph]);
      calm <= (ph % 3 == 1);
      n = (caps[ph] >= 127) ? 280 : 110;
      for (int k = 0; k < n; k++) begin
        if (k == n / 2 && $urandom_range(0, 1) == 1) wait_idle();
        push_req(rand_item(k < n * 7 / 10, len_hint));
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    $display("Covered %0d operations and %0d capacity writes: %0d results checked,",
             ops_sent, cap_writes, results_seen);
    $display("  of which %0d full rejects and %0d out-of-range rejects.",
             full_seen, range_seen);
    if (errors == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/plil_pkg.sv
hdl/plil_dpath.sv
hdl/plil_ctrl.sv
hdl/positional_insert_remove_list_core.sv
hdl/plil_check.sv
verif/plil_list_checker.sv
verif/tb.sv
